// ===== rtl/midi_event_stream_parser_assert.svh =====
// ---------------------------------------------------------------------------
// midi_event_stream_parser assertion macros
// shared property wrappers for the parser checker
// ---------------------------------------------------------------------------
`ifndef MIDI_EVENT_STREAM_PARSER_ASSERT_SVH
`define MIDI_EVENT_STREAM_PARSER_ASSERT_SVH

// property checked out of reset only
`define MESP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// property checked on every edge, reset included
`define MESP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/mesp_pkg.sv =====
// ---------------------------------------------------------------------------
// mesp_pkg
// types and constants shared by the midi event stream parser
// ---------------------------------------------------------------------------
`default_nettype none

package mesp_pkg;

    // longest variable-length size field, in bytes
    localparam int unsigned MAX_LENGTH_BYTES = 4;
    localparam logic [2:0]  MAX_LEN_CNT      = 3'(MAX_LENGTH_BYTES);

    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned OUT_DATA_W = 144;

    localparam logic [23:0] DEFAULT_TEMPO = 24'd500000;
    localparam logic [7:0]  HI_MASK       = 8'hF0;
    localparam logic [7:0]  CH_MASK       = 8'h0F;
    localparam logic [7:0]  DATA_MASK     = 8'h7F;
    localparam logic [7:0]  NONE_BYTE     = 8'hFF;

    // status bytes and meta types
    localparam logic [7:0] ST_NOTE_OFF  = 8'h80;
    localparam logic [7:0] ST_NOTE_ON   = 8'h90;
    localparam logic [7:0] ST_PROGRAM   = 8'hC0;
    localparam logic [7:0] ST_CH_PRESS  = 8'hD0;
    localparam logic [7:0] ST_SYSEX     = 8'hF0;
    localparam logic [7:0] ST_SYSEX_ESC = 8'hF7;
    localparam logic [7:0] ST_META      = 8'hFF;
    localparam logic [7:0] MT_CH_PREFIX = 8'h20;
    localparam logic [7:0] MT_PORT      = 8'h21;
    localparam logic [7:0] MT_TEMPO     = 8'h51;

    typedef enum logic [2:0] {
        KIND_CHANNEL   = 3'd0,
        KIND_META_HDR  = 3'd1,
        KIND_SYSEX_HDR = 3'd2,
        KIND_PAYLOAD   = 3'd3,
        KIND_NO_STATUS = 3'd4,
        KIND_UNKNOWN   = 3'd5,
        KIND_TOO_LONG  = 3'd6
    } t_kind;

    typedef enum logic [5:0] {
        PH_IDLE     = 6'b000001,
        PH_DATA1    = 6'b000010,
        PH_DATA2    = 6'b000100,
        PH_METATYPE = 6'b001000,
        PH_LENGTH   = 6'b010000,
        PH_PAYLOAD  = 6'b100000
    } t_phase;

    typedef struct packed {
        logic [7:0]  in_byte;
        logic [31:0] event_time;
    } t_item;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  status;
        logic [7:0]  data_first;
        logic [7:0]  data_second;
        logic [7:0]  meta_code;
        logic [27:0] payload_length;
        logic [7:0]  payload_byte;
        logic        last;
        logic [7:0]  channel_now;
        logic [7:0]  port_now;
        logic [23:0] tempo;
        logic [31:0] event_tick;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/mesp_in_reg.sv =====
// ---------------------------------------------------------------------------
// mesp_in_reg
// input register stage holding one stream byte and its tick time
// ---------------------------------------------------------------------------
`default_nettype none

module mesp_in_reg
    import mesp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_item i_item,
    input  wire logic  i_advance,
    output logic       o_valid,
    output t_item      o_item
);

    logic  r_valid;
    t_item r_item;
    logic  w_load;

    assign o_ready = !r_valid || i_advance;
    assign w_load  = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mesp_core.sv =====
// ---------------------------------------------------------------------------
// mesp_core
// parse state and combinational decode of one event byte
// ---------------------------------------------------------------------------
`default_nettype none

module mesp_core
    import mesp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_step,
    input  wire t_item i_item,
    output logic       o_res_valid,
    output t_result    o_res
);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_running, n_running;
    logic [7:0]  r_ev_status, n_ev_status;
    logic [7:0]  r_held, n_held;
    logic [7:0]  r_meta_code, n_meta_code;
    logic [27:0] r_len_acc, n_len_acc;
    logic [2:0]  r_len_cnt, n_len_cnt;
    logic [27:0] r_remain, n_remain;
    logic [7:0]  r_first_pl, n_first_pl;
    logic [23:0] r_tempo_acc, n_tempo_acc;
    logic [7:0]  r_chan, n_chan;
    logic [7:0]  r_port, n_port;
    logic [31:0] r_tick, n_tick;

    logic [7:0]  w_byte;
    logic        w_is_meta;
    logic [7:0]  w_mt;
    logic [2:0]  w_cnt_inc;
    logic [27:0] w_acc_next;
    logic        w_pl_last;

    assign w_byte     = i_item.in_byte;
    assign w_is_meta  = (r_ev_status == ST_META);
    assign w_mt       = w_is_meta ? r_meta_code : NONE_BYTE;
    assign w_cnt_inc  = r_len_cnt + 3'd1;
    assign w_acc_next = {r_len_acc[20:0], w_byte[6:0]};
    assign w_pl_last  = (r_remain <= 28'd1);

    always_comb begin
        logic       first_go;
        logic       finish_go;
        logic [7:0] fin_d1;
        logic [7:0] fin_d2;
        logic [7:0] hi;

        n_phase     = r_phase;
        n_running   = r_running;
        n_ev_status = r_ev_status;
        n_held      = r_held;
        n_meta_code = r_meta_code;
        n_len_acc   = r_len_acc;
        n_len_cnt   = r_len_cnt;
        n_remain    = r_remain;
        n_first_pl  = r_first_pl;
        n_tempo_acc = r_tempo_acc;
        n_chan      = r_chan;
        n_port      = r_port;
        n_tick      = r_tick;

        first_go  = 1'b0;
        finish_go = 1'b0;
        fin_d1    = w_byte;
        fin_d2    = NONE_BYTE;
        hi        = 8'd0;

        o_res_valid          = 1'b0;
        o_res.kind           = KIND_CHANNEL;
        o_res.status         = r_ev_status;
        o_res.data_first     = 8'd0;
        o_res.data_second    = NONE_BYTE;
        o_res.meta_code      = NONE_BYTE;
        o_res.payload_length = 28'd0;
        o_res.payload_byte   = 8'd0;
        o_res.last           = 1'b1;
        o_res.tempo          = DEFAULT_TEMPO;

        if (i_step) begin
            case (r_phase)
                PH_DATA1: begin
                    first_go = 1'b1;
                end
                PH_DATA2: begin
                    finish_go = 1'b1;
                    fin_d1    = r_held;
                    fin_d2    = w_byte;
                end
                PH_METATYPE: begin
                    n_meta_code = w_byte;
                    n_len_acc   = 28'd0;
                    n_len_cnt   = 3'd0;
                    n_phase     = PH_LENGTH;
                end
                PH_LENGTH: begin
                    n_len_cnt = w_cnt_inc;
                    n_len_acc = w_acc_next;
                    if (w_byte[7]) begin
                        if (w_cnt_inc >= MAX_LEN_CNT) begin
                            n_phase         = PH_IDLE;
                            o_res_valid     = 1'b1;
                            o_res.kind      = KIND_TOO_LONG;
                            o_res.meta_code = w_mt;
                        end
                    end else begin
                        n_remain    = w_acc_next;
                        n_first_pl  = NONE_BYTE;
                        n_tempo_acc = 24'd0;
                        if (w_acc_next == 28'd0) begin
                            n_phase = PH_IDLE;
                            // zero-length prefix meta sets the prefix to none
                            if (w_is_meta && r_meta_code == MT_CH_PREFIX) begin
                                n_chan = NONE_BYTE;
                            end else if (w_is_meta && r_meta_code == MT_PORT) begin
                                n_port = NONE_BYTE;
                            end
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                        o_res_valid          = 1'b1;
                        o_res.kind           = w_is_meta ? KIND_META_HDR : KIND_SYSEX_HDR;
                        o_res.meta_code      = w_mt;
                        o_res.payload_length = w_acc_next;
                        o_res.last           = (w_acc_next == 28'd0);
                    end
                end
                PH_PAYLOAD: begin
                    if (r_remain == r_len_acc) begin
                        n_first_pl = w_byte;
                    end
                    n_tempo_acc = {r_tempo_acc[15:0], w_byte};
                    n_remain    = w_pl_last ? 28'd0 : r_remain - 28'd1;
                    if (w_pl_last) begin
                        n_phase = PH_IDLE;
                        if (w_is_meta && r_meta_code == MT_CH_PREFIX) begin
                            n_chan = n_first_pl;
                        end else if (w_is_meta && r_meta_code == MT_PORT) begin
                            n_port = n_first_pl;
                        end else if (w_is_meta && r_meta_code == MT_TEMPO
                                     && r_len_acc == 28'd3) begin
                            o_res.tempo = n_tempo_acc;
                        end
                    end
                    o_res_valid          = 1'b1;
                    o_res.kind           = KIND_PAYLOAD;
                    o_res.meta_code      = w_mt;
                    o_res.payload_length = r_len_acc;
                    o_res.payload_byte   = w_byte;
                    o_res.last           = w_pl_last;
                end
                default: begin
                    // idle, and any stray phase code, starts a new event
                    n_phase = PH_IDLE;
                    n_tick  = i_item.event_time;
                    if (!w_byte[7]) begin
                        if (!r_running[7]) begin
                            o_res_valid  = 1'b1;
                            o_res.kind   = KIND_NO_STATUS;
                            o_res.status = r_running;
                        end else begin
                            n_ev_status = r_running;
                            first_go    = 1'b1;
                        end
                    end else if (w_byte < ST_SYSEX) begin
                        n_running   = w_byte;
                        n_ev_status = w_byte;
                        n_phase     = PH_DATA1;
                    end else if (w_byte == ST_SYSEX || w_byte == ST_SYSEX_ESC
                                 || w_byte == ST_META) begin
                        n_ev_status = w_byte;
                        n_len_acc   = 28'd0;
                        n_len_cnt   = 3'd0;
                        n_phase     = (w_byte == ST_META) ? PH_METATYPE : PH_LENGTH;
                    end else begin
                        o_res_valid  = 1'b1;
                        o_res.kind   = KIND_UNKNOWN;
                        o_res.status = w_byte;
                    end
                end
            endcase

            hi = n_ev_status & HI_MASK;

            if (first_go) begin
                if (hi == ST_PROGRAM || hi == ST_CH_PRESS) begin
                    finish_go = 1'b1;
                    fin_d1    = w_byte;
                    fin_d2    = NONE_BYTE;
                end else begin
                    n_held  = w_byte;
                    n_phase = PH_DATA2;
                end
            end

            if (finish_go) begin
                if (hi == ST_NOTE_OFF || hi == ST_NOTE_ON) begin
                    fin_d1 = fin_d1 & DATA_MASK;
                    fin_d2 = fin_d2 & DATA_MASK;
                end
                n_chan            = n_ev_status & CH_MASK;
                n_phase           = PH_IDLE;
                o_res_valid       = 1'b1;
                o_res.kind        = KIND_CHANNEL;
                o_res.status      = n_ev_status;
                o_res.data_first  = fin_d1;
                o_res.data_second = fin_d2;
            end
        end

        o_res.channel_now = n_chan;
        o_res.port_now    = n_port;
        o_res.event_tick  = n_tick;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_running   <= 8'd0;
            r_ev_status <= 8'd0;
            r_held      <= 8'd0;
            r_meta_code <= 8'd0;
            r_len_acc   <= 28'd0;
            r_len_cnt   <= 3'd0;
            r_remain    <= 28'd0;
            r_first_pl  <= NONE_BYTE;
            r_tempo_acc <= 24'd0;
            r_chan      <= 8'd0;
            r_port      <= 8'd0;
            r_tick      <= 32'd0;
        end else begin
            r_phase     <= n_phase;
            r_running   <= n_running;
            r_ev_status <= n_ev_status;
            r_held      <= n_held;
            r_meta_code <= n_meta_code;
            r_len_acc   <= n_len_acc;
            r_len_cnt   <= n_len_cnt;
            r_remain    <= n_remain;
            r_first_pl  <= n_first_pl;
            r_tempo_acc <= n_tempo_acc;
            r_chan      <= n_chan;
            r_port      <= n_port;
            r_tick      <= n_tick;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mesp_out_reg.sv =====
// ---------------------------------------------------------------------------
// mesp_out_reg
// result register facing the output stream
// ---------------------------------------------------------------------------
`default_nettype none

module mesp_out_reg
    import mesp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_res_valid,
    input  wire t_result i_res,
    input  wire logic    i_ready,
    output logic         o_advance,
    output logic         o_valid,
    output t_result      o_res
);

    logic    r_valid;
    t_result r_res;

    // register is free when empty or being drained this cycle
    assign o_advance = !r_valid || i_ready;
    assign o_valid   = r_valid;
    assign o_res     = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/midi_event_stream_parser.sv =====
// ---------------------------------------------------------------------------
// midi_event_stream_parser
// running-status midi file event parser, one event-body byte per request
// ---------------------------------------------------------------------------
// takes one byte of midi file event bodies (no delta times) per request and
// gives at most one result per byte. throughput is one byte per clock while
// the result stream does not stall; each byte is held in the input register
// and its result is stored in the result register as it moves on. the rate
// is set by the combinational decode between the two registers, which reads
// and updates the whole parse state in one pass. bytes that only advance
// the parse (status, first data of a two-byte message, meta type, length
// continuation) give no result. channel messages come out whole, meta and
// sysex give a header carrying the decoded size and then one payload result
// per byte with tlast on the final one. error kinds (no running status,
// unknown system status, size field too long) are single results with tlast.
// ---------------------------------------------------------------------------
`default_nettype none

module midi_event_stream_parser
    import mesp_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // input stream
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // [7:0] in_byte, [39:8] event_time
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // result stream
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // [7:0] status, [15:8] data_first, [23:16] data_second, [31:24] meta_code,
    // [59:32] payload_length, [67:60] payload_byte, [75:68] channel_now,
    // [83:76] port_now, [107:84] tempo, [139:108] event_tick, [143:140] zero
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata,
    // [2:0] kind
    output logic [2:0]                 o_m_axis_tuser,
    // last
    output logic                       o_m_axis_tlast
);

    t_item   w_in_item;
    t_item   w_stage_item;
    logic    w_stage_valid;
    logic    w_advance;
    logic    w_step;
    logic    w_res_valid;
    t_result w_res;
    t_result w_out;

    assign w_in_item.in_byte    = i_s_axis_tdata[7:0];
    assign w_in_item.event_time = i_s_axis_tdata[39:8];

    // input register, emptied whenever the result register can take a result
    mesp_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_item    (w_in_item),
        .i_advance (w_advance),
        .o_valid   (w_stage_valid),
        .o_item    (w_stage_item)
    );

    // a held byte is decoded in the cycle it moves on
    assign w_step = w_stage_valid && w_advance;

    mesp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_item      (w_stage_item),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    mesp_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (w_res_valid),
        .i_res       (w_res),
        .i_ready     (i_m_axis_tready),
        .o_advance   (w_advance),
        .o_valid     (o_m_axis_tvalid),
        .o_res       (w_out)
    );

    // pack result fields, lowest first
    assign o_m_axis_tdata = {4'd0,
                             w_out.event_tick,
                             w_out.tempo,
                             w_out.port_now,
                             w_out.channel_now,
                             w_out.payload_byte,
                             w_out.payload_length,
                             w_out.meta_code,
                             w_out.data_second,
                             w_out.data_first,
                             w_out.status};
    assign o_m_axis_tuser = w_out.kind;
    assign o_m_axis_tlast = w_out.last;

endmodule

`default_nettype wire

// ===== rtl/mesp_checker.sv =====
// ---------------------------------------------------------------------------
// mesp_checker
// port-level checks on the parser result stream
// ---------------------------------------------------------------------------
`default_nettype none

`include "midi_event_stream_parser_assert.svh"

module mesp_checker
    import mesp_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_s_axis_tvalid,
    input wire logic                  i_s_axis_tready,
    input wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    input wire logic                  i_m_axis_tvalid,
    input wire logic                  i_m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] i_m_axis_tdata,
    input wire logic [2:0]            i_m_axis_tuser,
    input wire logic                  i_m_axis_tlast
);

    logic w_unused;
    assign w_unused = i_s_axis_tvalid ^ i_s_axis_tready ^ (^i_s_axis_tdata);

    `MESP_ASSERT_ALWAYS(a_idle_after_reset, i_clk, !i_rst_n |=> !i_m_axis_tvalid, "result after reset")

    `MESP_ASSERT(a_stall_hold, i_clk, i_rst_n, i_m_axis_tvalid && !i_m_axis_tready |=> i_m_axis_tvalid && $stable(i_m_axis_tdata) && $stable(i_m_axis_tuser), "stalled result changed")

    `MESP_ASSERT(a_kind_range, i_clk, i_rst_n, i_m_axis_tvalid |-> i_m_axis_tuser != 3'd7, "undefined result kind")

    `MESP_ASSERT(a_single_is_last, i_clk, i_rst_n, i_m_axis_tvalid && (i_m_axis_tuser == KIND_CHANNEL || i_m_axis_tuser == KIND_NO_STATUS || i_m_axis_tuser == KIND_UNKNOWN || i_m_axis_tuser == KIND_TOO_LONG) |-> i_m_axis_tlast, "single result without last")

    `MESP_ASSERT(a_payload_byte_zero, i_clk, i_rst_n, i_m_axis_tvalid && i_m_axis_tuser != KIND_PAYLOAD |-> i_m_axis_tdata[67:60] == 8'd0, "payload byte outside payload")

endmodule

bind midi_event_stream_parser mesp_checker u_mesp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .i_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata),
    .i_m_axis_tuser  (o_m_axis_tuser),
    .i_m_axis_tlast  (o_m_axis_tlast)
);

`default_nettype wire
